// ===== rtl/v3m_pkg.sv =====
// Shared types, constants and helper functions of the 3D vector maths unit.
package v3m_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned SW         = 70;

  localparam logic signed [SW-1:0] SAT_HI = 70'sd2147483647;
  localparam logic signed [SW-1:0] SAT_LO = -70'sd2147483648;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_SCALE   = 4'd2,
    OP_ADDSCAL = 4'd3,
    OP_SUBSCAL = 4'd4,
    OP_DOT     = 4'd5,
    OP_CROSS   = 4'd6,
    OP_MAG     = 4'd7,
    OP_DIST    = 4'd8,
    OP_NORM    = 4'd9,
    OP_PROJ    = 4'd10,
    OP_TRUNC   = 4'd11,
    OP_EQ      = 4'd12
  } op_t;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] scalar_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] rscalar;
    logic               equal_flag;
    logic               zero_length_error;
  } out_t;

  typedef struct packed {
    op_t                op;
    out_t               res;
    logic [2:0][31:0]   dx;
    logic [63:0]        dy;
    logic [2:0]         dsg;
    logic [63:0]        dd;
    logic signed [31:0] s;
    logic               zl;
  } cr_t;

  typedef struct packed {
    op_t        op;
    out_t       res;
    logic [2:0] dsg;
    logic [2:0] big;
    logic       pass;
    logic       zl;
  } tl_t;

  function automatic int nx(input int k);
    return (k == 2) ? 0 : k + 1;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (32'h0 - v) : v;
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? (33'h0 - v) : v;
  endfunction

  function automatic logic signed [31:0] sat_s(input logic signed [SW-1:0] v);
    if (v > SAT_HI) begin
      return 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat_sm(input logic neg, input logic [31:0] m);
    if (!neg) begin
      return (m > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : m;
    end
    return (m > 32'h8000_0000) ? 32'h8000_0000 : (32'h0 - m);
  endfunction

endpackage

// ===== rtl/v3m_front.sv =====
// Front stages: operand selection, products, sums and early results.
module v3m_front #(
  parameter int unsigned FRAC_BITS = v3m_pkg::FRAC_BITS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  v3m_pkg::in_t   in_data,
  output logic           out_valid,
  output v3m_pkg::cr_t   out_cr,
  output logic [63:0]    out_rad
);

  logic                 s0_v_r;
  v3m_pkg::in_t         s0_d_r;

  logic                 s1_v_r;
  v3m_pkg::in_t         s1_d_r;
  v3m_pkg::out_t        s1_res_r;
  logic [32:0]          s1_x_r [6];
  logic [32:0]          s1_y_r [6];
  logic [5:0]           s1_ng_r;

  logic                 s2_v_r;
  v3m_pkg::in_t         s2_d_r;
  v3m_pkg::out_t        s2_res_r;
  logic [65:0]          s2_p_r [6];
  logic [5:0]           s2_ng_r;

  logic                 s3_v_r;
  v3m_pkg::in_t         s3_d_r;
  v3m_pkg::out_t        s3_res_r;
  logic signed [v3m_pkg::SW-1:0] s3_lane_r [3];
  logic signed [v3m_pkg::SW-1:0] s3_tot_r;
  logic [67:0]          s3_sq_r;
  logic [67:0]          s3_sb_r;

  logic                 s4_v_r;
  v3m_pkg::cr_t         s4_cr_r;
  logic [63:0]          s4_rad_r;

  v3m_pkg::out_t        res1_nxt;
  logic [32:0]          x1_nxt [6];
  logic [32:0]          y1_nxt [6];
  logic [5:0]           ng1_nxt;
  logic signed [v3m_pkg::SW-1:0] lane3_nxt [3];
  logic signed [v3m_pkg::SW-1:0] tot3_nxt;
  logic [67:0]          sq3_nxt;
  logic [67:0]          sb3_nxt;
  v3m_pkg::cr_t         cr4_nxt;
  logic [63:0]          rad4_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  // operand selection and adder results
  always_comb begin
    logic signed [31:0] av [3];
    logic signed [31:0] bv [3];
    logic signed [31:0] sv;
    logic signed [31:0] rv [3];
    logic signed [32:0] dif;
    av[0] = s0_d_r.ax;
    av[1] = s0_d_r.ay;
    av[2] = s0_d_r.az;
    bv[0] = s0_d_r.bx;
    bv[1] = s0_d_r.by;
    bv[2] = s0_d_r.bz;
    sv    = s0_d_r.scalar_in;
    res1_nxt = '0;
    ng1_nxt  = '0;
    for (int k = 0; k < 6; k++) begin
      x1_nxt[k] = '0;
      y1_nxt[k] = '0;
    end
    for (int k = 0; k < 3; k++) begin
      rv[k] = '0;
      dif   = 33'(av[k]) - 33'(bv[k]);
      case (v3m_pkg::op_t'(s0_d_r.op))
        v3m_pkg::OP_ADD: begin
          rv[k] = v3m_pkg::sat_s(v3m_pkg::SW'(av[k]) + v3m_pkg::SW'(bv[k]));
        end
        v3m_pkg::OP_SUB: begin
          rv[k] = v3m_pkg::sat_s(v3m_pkg::SW'(av[k]) - v3m_pkg::SW'(bv[k]));
        end
        v3m_pkg::OP_ADDSCAL: begin
          rv[k] = v3m_pkg::sat_s(v3m_pkg::SW'(av[k]) + v3m_pkg::SW'(sv));
        end
        v3m_pkg::OP_SUBSCAL: begin
          rv[k] = v3m_pkg::sat_s(v3m_pkg::SW'(av[k]) - v3m_pkg::SW'(sv));
        end
        v3m_pkg::OP_SCALE: begin
          x1_nxt[k]  = {1'b0, v3m_pkg::mag32(av[k])};
          y1_nxt[k]  = {1'b0, v3m_pkg::mag32(sv)};
          ng1_nxt[k] = av[k][31] ^ sv[31];
        end
        v3m_pkg::OP_DOT: begin
          x1_nxt[k]  = {1'b0, v3m_pkg::mag32(av[k])};
          y1_nxt[k]  = {1'b0, v3m_pkg::mag32(bv[k])};
          ng1_nxt[k] = av[k][31] ^ bv[k][31];
        end
        v3m_pkg::OP_PROJ: begin
          x1_nxt[k]    = {1'b0, v3m_pkg::mag32(av[k])};
          y1_nxt[k]    = {1'b0, v3m_pkg::mag32(bv[k])};
          ng1_nxt[k]   = av[k][31] ^ bv[k][31];
          x1_nxt[k+3]  = {1'b0, v3m_pkg::mag32(bv[k])};
          y1_nxt[k+3]  = {1'b0, v3m_pkg::mag32(bv[k])};
        end
        v3m_pkg::OP_CROSS: begin
          x1_nxt[k]   = {1'b0, v3m_pkg::mag32(av[v3m_pkg::nx(k)])};
          y1_nxt[k]   = {1'b0, v3m_pkg::mag32(bv[v3m_pkg::nx(v3m_pkg::nx(k))])};
          ng1_nxt[k]  = av[v3m_pkg::nx(k)][31] ^ bv[v3m_pkg::nx(v3m_pkg::nx(k))][31];
          x1_nxt[k+3] = {1'b0, v3m_pkg::mag32(av[v3m_pkg::nx(v3m_pkg::nx(k))])};
          y1_nxt[k+3] = {1'b0, v3m_pkg::mag32(bv[v3m_pkg::nx(k)])};
          ng1_nxt[k+3] = ~(av[v3m_pkg::nx(v3m_pkg::nx(k))][31] ^ bv[v3m_pkg::nx(k)][31]);
        end
        v3m_pkg::OP_MAG, v3m_pkg::OP_NORM: begin
          x1_nxt[k] = {1'b0, v3m_pkg::mag32(av[k])};
          y1_nxt[k] = {1'b0, v3m_pkg::mag32(av[k])};
        end
        v3m_pkg::OP_TRUNC: begin
          x1_nxt[k] = {1'b0, v3m_pkg::mag32(av[k])};
          y1_nxt[k] = {1'b0, v3m_pkg::mag32(av[k])};
          rv[k]     = av[k];
        end
        v3m_pkg::OP_DIST: begin
          x1_nxt[k] = v3m_pkg::mag33(dif);
          y1_nxt[k] = v3m_pkg::mag33(dif);
        end
        default: begin
        end
      endcase
    end
    res1_nxt.rx = rv[0];
    res1_nxt.ry = rv[1];
    res1_nxt.rz = rv[2];
    res1_nxt.equal_flag = (v3m_pkg::op_t'(s0_d_r.op) == v3m_pkg::OP_EQ) &&
                          (av[0] == bv[0]) && (av[1] == bv[1]) && (av[2] == bv[2]);
  end

  // signed sums of the products
  always_comb begin
    logic signed [v3m_pkg::SW-1:0] sp [6];
    for (int k = 0; k < 6; k++) begin
      sp[k] = s2_ng_r[k] ? -$signed(v3m_pkg::SW'(s2_p_r[k])) : $signed(v3m_pkg::SW'(s2_p_r[k]));
    end
    for (int k = 0; k < 3; k++) begin
      lane3_nxt[k] = sp[k] + sp[k+3];
    end
    tot3_nxt = sp[0] + sp[1] + sp[2];
    sq3_nxt  = 68'(s2_p_r[0]) + 68'(s2_p_r[1]) + 68'(s2_p_r[2]);
    sb3_nxt  = 68'(s2_p_r[3]) + 68'(s2_p_r[4]) + 68'(s2_p_r[5]);
  end

  // fixed-point results, root operand and divider operands
  always_comb begin
    logic signed [31:0] av [3];
    logic signed [31:0] bv [3];
    logic signed [31:0] rv [3];
    logic signed [v3m_pkg::SW-1:0] totm;
    v3m_pkg::op_t op;
    av[0] = s3_d_r.ax;
    av[1] = s3_d_r.ay;
    av[2] = s3_d_r.az;
    bv[0] = s3_d_r.bx;
    bv[1] = s3_d_r.by;
    bv[2] = s3_d_r.bz;
    op    = v3m_pkg::op_t'(s3_d_r.op);
    totm  = s3_tot_r[v3m_pkg::SW-1] ? -s3_tot_r : s3_tot_r;
    cr4_nxt     = '0;
    cr4_nxt.op  = op;
    cr4_nxt.res = s3_res_r;
    cr4_nxt.dd  = s3_sb_r[63:0];
    cr4_nxt.s   = s3_d_r.scalar_in;
    cr4_nxt.zl  = (op == v3m_pkg::OP_PROJ) ? (s3_sb_r == '0) : (s3_sq_r == '0);
    rv[0] = s3_res_r.rx;
    rv[1] = s3_res_r.ry;
    rv[2] = s3_res_r.rz;
    for (int k = 0; k < 3; k++) begin
      case (op)
        v3m_pkg::OP_SCALE, v3m_pkg::OP_CROSS: begin
          rv[k] = v3m_pkg::sat_s(s3_lane_r[k] >>> FRAC_BITS);
        end
        v3m_pkg::OP_NORM: begin
          cr4_nxt.dx[k]  = v3m_pkg::mag32(av[k]);
          cr4_nxt.dsg[k] = av[k][31];
        end
        v3m_pkg::OP_TRUNC: begin
          cr4_nxt.dx[k]  = v3m_pkg::mag32(av[k]);
          cr4_nxt.dsg[k] = av[k][31] ^ s3_d_r.scalar_in[31];
        end
        v3m_pkg::OP_PROJ: begin
          cr4_nxt.dx[k]  = v3m_pkg::mag32(bv[k]);
          cr4_nxt.dsg[k] = bv[k][31] ^ s3_tot_r[v3m_pkg::SW-1];
        end
        default: begin
        end
      endcase
    end
    cr4_nxt.res.rx = rv[0];
    cr4_nxt.res.ry = rv[1];
    cr4_nxt.res.rz = rv[2];
    case (op)
      v3m_pkg::OP_DOT:   cr4_nxt.res.rscalar = v3m_pkg::sat_s(s3_tot_r >>> FRAC_BITS);
      v3m_pkg::OP_NORM:  cr4_nxt.dy = 64'(1) << FRAC_BITS;
      v3m_pkg::OP_TRUNC: cr4_nxt.dy = 64'(v3m_pkg::mag32(s3_d_r.scalar_in));
      v3m_pkg::OP_PROJ:  cr4_nxt.dy = totm[63:0];
      default: begin
      end
    endcase
    if (op == v3m_pkg::OP_DIST && s3_sq_r >= 68'(64'h4000_0000_0000_0000)) begin
      rad4_nxt = 64'h4000_0000_0000_0000;
    end else begin
      rad4_nxt = s3_sq_r[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_d_r   <= in_data;
      s1_d_r   <= s0_d_r;
      s1_res_r <= res1_nxt;
      s1_ng_r  <= ng1_nxt;
      s2_d_r   <= s1_d_r;
      s2_res_r <= s1_res_r;
      s2_ng_r  <= s1_ng_r;
      for (int k = 0; k < 6; k++) begin
        s1_x_r[k] <= x1_nxt[k];
        s1_y_r[k] <= y1_nxt[k];
        s2_p_r[k] <= 66'(s1_x_r[k]) * 66'(s1_y_r[k]);
      end
      s3_d_r   <= s2_d_r;
      s3_res_r <= s2_res_r;
      for (int k = 0; k < 3; k++) begin
        s3_lane_r[k] <= lane3_nxt[k];
      end
      s3_tot_r <= tot3_nxt;
      s3_sq_r  <= sq3_nxt;
      s3_sb_r  <= sb3_nxt;
      s4_cr_r  <= cr4_nxt;
      s4_rad_r <= rad4_nxt;
    end
  end

  assign out_valid = s4_v_r;
  assign out_cr    = s4_cr_r;
  assign out_rad   = s4_rad_r;

endmodule

// ===== rtl/v3m_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module v3m_sqrt (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  v3m_pkg::cr_t  in_cr,
  input  logic [63:0]   in_rad,
  output logic          out_valid,
  output v3m_pkg::cr_t  out_cr,
  output logic [31:0]   out_root
);

  localparam int unsigned N = v3m_pkg::SQRT_STEPS;

  logic [N-1:0]  v_r;
  v3m_pkg::cr_t  cr_r   [N];
  logic [63:0]   rad_r  [N];
  logic [35:0]   rem_r  [N];
  logic [31:0]   root_r [N];

  logic [35:0]   rem_nxt  [N];
  logic [31:0]   root_nxt [N];
  logic [63:0]   rad_nxt  [N];

  always_comb begin
    logic [35:0] rp [N];
    logic [31:0] qp [N];
    logic [63:0] vp [N];
    logic [35:0] rs;
    logic [35:0] tr;
    logic        ge;
    rp[0] = '0;
    qp[0] = '0;
    vp[0] = in_rad;
    for (int k = 1; k < N; k++) begin
      rp[k] = rem_r[k-1];
      qp[k] = root_r[k-1];
      vp[k] = rad_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      rs = {rp[k][33:0], vp[k][63:62]};
      tr = {2'b00, qp[k], 2'b01};
      ge = rs >= tr;
      rem_nxt[k]  = ge ? (rs - tr) : rs;
      root_nxt[k] = {qp[k][30:0], ge};
      rad_nxt[k]  = {vp[k][61:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cr_r[0] <= in_cr;
      for (int k = 1; k < N; k++) begin
        cr_r[k] <= cr_r[k-1];
      end
      for (int k = 0; k < N; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        rad_r[k]  <= rad_nxt[k];
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_cr    = cr_r[N-1];
  assign out_root  = root_r[N-1];

endmodule

// ===== rtl/v3m_div.sv =====
// Divider lanes: wide products, range check and pipelined restoring division.
module v3m_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  v3m_pkg::cr_t     in_cr,
  input  logic [31:0]      in_root,
  output logic             out_valid,
  output v3m_pkg::tl_t     out_tl,
  output logic [2:0][31:0] out_q
);

  localparam int unsigned N = v3m_pkg::DIV_STEPS;

  logic              p1_v_r;
  v3m_pkg::tl_t      p1_tl_r;
  logic [63:0]       p1_t0_r [3];
  logic [63:0]       p1_t1_r [3];
  logic [63:0]       p1_d_r;

  logic              p2_v_r;
  v3m_pkg::tl_t      p2_tl_r;
  logic [63:0]       p2_rem_r [3];
  logic [31:0]       p2_lo_r  [3];
  logic [63:0]       p2_d_r;

  logic [N-1:0]      v_r;
  v3m_pkg::tl_t      tl_r  [N];
  logic [63:0]       d_r   [N];
  logic [63:0]       rem_r [N][3];
  logic [31:0]       lo_r  [N][3];

  v3m_pkg::tl_t      tl1_nxt;
  logic [63:0]       d1_nxt;
  v3m_pkg::tl_t      tl2_nxt;
  logic [63:0]       rem2_nxt [3];
  logic [31:0]       lo2_nxt  [3];
  logic [63:0]       rem_nxt [N][3];
  logic [31:0]       lo_nxt  [N][3];

  always_comb begin
    tl1_nxt      = '0;
    tl1_nxt.op   = in_cr.op;
    tl1_nxt.res  = in_cr.res;
    tl1_nxt.dsg  = in_cr.dsg;
    tl1_nxt.zl   = in_cr.zl;
    tl1_nxt.pass = (in_cr.op == v3m_pkg::OP_TRUNC) && !in_cr.s[31] &&
                   ($unsigned(in_cr.s) >= in_root);
    if (in_cr.op == v3m_pkg::OP_MAG || in_cr.op == v3m_pkg::OP_DIST) begin
      tl1_nxt.res.rscalar = v3m_pkg::sat_sm(1'b0, in_root);
    end
    d1_nxt = (in_cr.op == v3m_pkg::OP_PROJ) ? in_cr.dd : {32'h0, in_root};
  end

  always_comb begin
    logic [95:0] num;
    tl2_nxt = p1_tl_r;
    for (int k = 0; k < 3; k++) begin
      num = {32'h0, p1_t0_r[k]} + {p1_t1_r[k], 32'h0};
      tl2_nxt.big[k] = num[95:32] >= p1_d_r;
      rem2_nxt[k]    = num[95:32];
      lo2_nxt[k]     = num[31:0];
    end
  end

  always_comb begin
    logic [63:0] rp;
    logic [31:0] lp;
    logic [64:0] rs;
    logic [63:0] dv;
    logic        ge;
    for (int s = 0; s < N; s++) begin
      dv = (s == 0) ? p2_d_r : d_r[(s == 0) ? 0 : s-1];
      for (int k = 0; k < 3; k++) begin
        rp = (s == 0) ? p2_rem_r[k] : rem_r[(s == 0) ? 0 : s-1][k];
        lp = (s == 0) ? p2_lo_r[k]  : lo_r[(s == 0) ? 0 : s-1][k];
        rs = {rp, lp[31]};
        ge = rs >= {1'b0, dv};
        rem_nxt[s][k] = ge ? 64'(rs - {1'b0, dv}) : rs[63:0];
        lo_nxt[s][k]  = {lp[30:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      v_r    <= '0;
    end else if (en) begin
      p1_v_r <= in_valid;
      p2_v_r <= p1_v_r;
      v_r    <= {v_r[N-2:0], p2_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_tl_r <= tl1_nxt;
      p1_d_r  <= d1_nxt;
      for (int k = 0; k < 3; k++) begin
        p1_t0_r[k] <= 64'(in_cr.dx[k]) * 64'(in_cr.dy[31:0]);
        p1_t1_r[k] <= 64'(in_cr.dx[k]) * 64'(in_cr.dy[63:32]);
        p2_rem_r[k] <= rem2_nxt[k];
        p2_lo_r[k]  <= lo2_nxt[k];
      end
      p2_tl_r <= tl2_nxt;
      p2_d_r  <= p1_d_r;
      tl_r[0] <= p2_tl_r;
      d_r[0]  <= p2_d_r;
      for (int s = 1; s < N; s++) begin
        tl_r[s] <= tl_r[s-1];
        d_r[s]  <= d_r[s-1];
      end
      for (int s = 0; s < N; s++) begin
        for (int k = 0; k < 3; k++) begin
          rem_r[s][k] <= rem_nxt[s][k];
          lo_r[s][k]  <= lo_nxt[s][k];
        end
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_tl    = tl_r[N-1];
  assign out_q[0]  = lo_r[N-1][0];
  assign out_q[1]  = lo_r[N-1][1];
  assign out_q[2]  = lo_r[N-1][2];

endmodule

// ===== rtl/vec3_math_unit.sv =====
// Top level of the 3D vector maths unit: pipeline, result selection and output register.
// Throughput: one word per cycle; every stage advances together while the output
// register is empty or being taken, so in_ready is low only while a held result waits.
// Depth is set by the 32-stage square root and the 32-stage divider chains.
// Reset (rst_n low, synchronous) clears every stage valid bit; data is not reset.
module vec3_math_unit #(
  parameter int unsigned FRAC_BITS = v3m_pkg::FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  v3m_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output v3m_pkg::out_t out_data
);

  logic             en;
  logic             fr_valid;
  v3m_pkg::cr_t     fr_cr;
  logic [63:0]      fr_rad;
  logic             sq_valid;
  v3m_pkg::cr_t     sq_cr;
  logic [31:0]      sq_root;
  logic             dv_valid;
  v3m_pkg::tl_t     dv_tl;
  logic [2:0][31:0] dv_q;

  logic             out_valid_r;
  v3m_pkg::out_t    out_data_r;
  v3m_pkg::out_t    out_data_nxt;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  v3m_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (fr_valid),
    .out_cr    (fr_cr),
    .out_rad   (fr_rad)
  );

  v3m_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_cr     (fr_cr),
    .in_rad    (fr_rad),
    .out_valid (sq_valid),
    .out_cr    (sq_cr),
    .out_root  (sq_root)
  );

  v3m_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_cr     (sq_cr),
    .in_root   (sq_root),
    .out_valid (dv_valid),
    .out_tl    (dv_tl),
    .out_q     (dv_q)
  );

  always_comb begin
    logic signed [31:0] rv [3];
    out_data_nxt = dv_tl.res;
    for (int k = 0; k < 3; k++) begin
      rv[k] = v3m_pkg::sat_sm(dv_tl.dsg[k], dv_tl.big[k] ? 32'hFFFF_FFFF : dv_q[k]);
    end
    case (dv_tl.op)
      v3m_pkg::OP_NORM, v3m_pkg::OP_TRUNC, v3m_pkg::OP_PROJ: begin
        if (dv_tl.zl) begin
          out_data_nxt.rx = '0;
          out_data_nxt.ry = '0;
          out_data_nxt.rz = '0;
          out_data_nxt.zero_length_error = 1'b1;
        end else if (!dv_tl.pass) begin
          out_data_nxt.rx = rv[0];
          out_data_nxt.ry = rv[1];
          out_data_nxt.rz = rv[2];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_err_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.zero_length_error |->
      out_data_r.rx == '0 && out_data_r.ry == '0 && out_data_r.rz == '0 &&
      out_data_r.rscalar == '0)
    else $error("zero-length error with non-zero result");

  a_eq_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.equal_flag |->
      out_data_r.rx == '0 && out_data_r.ry == '0 && out_data_r.rz == '0 &&
      out_data_r.rscalar == '0 && !out_data_r.zero_length_error)
    else $error("equality word carries other results");

  a_scalar_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.rscalar != '0 |->
      out_data_r.rx == '0 && out_data_r.ry == '0 && out_data_r.rz == '0)
    else $error("scalar result with non-zero vector");

endmodule

// ===== tb/vec3_math_unit_checker.sv =====
// Checker for the 3D vector maths unit: watches both channels, predicts each result word and compares.
`timescale 1ns / 1ps
module vec3_math_unit_checker
  import v3m_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_ready,
  input  in_t   in_data,
  input  logic  out_valid,
  input  logic  out_ready,
  input  out_t  out_data,
  output int    err_count,
  output int    pending
);

  out_t result_q[$];

  function automatic logic [127:0] umag(input longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  function automatic logic [31:0] clamp_sm(input bit neg, input logic [127:0] m);
    logic [127:0] t;
    if (!neg) begin
      return (m > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end
    if (m > 128'h8000_0000) begin
      return 32'h8000_0000;
    end
    t = 128'd0 - m;
    return t[31:0];
  endfunction

  function automatic logic [31:0] clamp_l(input longint v);
    return clamp_sm(v < 0, umag(v));
  endfunction

  function automatic void mac(inout logic [127:0] p, inout logic [127:0] n,
                              input longint x, input longint y, input bit negate);
    logic [127:0] m;
    m = umag(x) * umag(y);
    if (((x < 0) != (y < 0)) != negate) begin
      n = n + m;
    end else begin
      p = p + m;
    end
  endfunction

  function automatic logic [31:0] floor_frac(input logic [127:0] p, input logic [127:0] n);
    if (p >= n) begin
      return clamp_sm(1'b0, (p - n) >> FRAC_BITS);
    end
    return clamp_sm(1'b1, (n - p + ((128'd1 << FRAC_BITS) - 1)) >> FRAC_BITS);
  endfunction

  function automatic logic [127:0] root_floor(input logic [127:0] v);
    logic [127:0] r;
    logic [127:0] bt;
    r  = 0;
    bt = 128'd1 << 62;
    while (bt > v) begin
      bt = bt >> 2;
    end
    while (bt != 0) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  function automatic out_t vec_result(input in_t w);
    longint       a[3];
    longint       b[3];
    longint       s;
    logic [127:0] p, n, sa, sb, m, sd, dm;
    logic [31:0]  rv[3];
    logic [31:0]  rs;
    bit           eq, zl, dneg;
    int           i, j, k;
    out_t         r;
    a[0] = w.ax; a[1] = w.ay; a[2] = w.az;
    b[0] = w.bx; b[1] = w.by; b[2] = w.bz;
    s = w.scalar_in;
    rv[0] = 0; rv[1] = 0; rv[2] = 0; rs = 0; eq = 0; zl = 0;
    p = 0; n = 0; sa = 0; sb = 0; sd = 0;
    for (i = 0; i < 3; i++) begin
      sa = sa + umag(a[i]) * umag(a[i]);
      sb = sb + umag(b[i]) * umag(b[i]);
    end
    case (w.op)
      OP_ADD:     for (i = 0; i < 3; i++) rv[i] = clamp_l(a[i] + b[i]);
      OP_SUB:     for (i = 0; i < 3; i++) rv[i] = clamp_l(a[i] - b[i]);
      OP_ADDSCAL: for (i = 0; i < 3; i++) rv[i] = clamp_l(a[i] + s);
      OP_SUBSCAL: for (i = 0; i < 3; i++) rv[i] = clamp_l(a[i] - s);
      OP_SCALE: begin
        for (i = 0; i < 3; i++) begin
          p = 0; n = 0;
          mac(p, n, a[i], s, 1'b0);
          rv[i] = floor_frac(p, n);
        end
      end
      OP_DOT: begin
        for (i = 0; i < 3; i++) mac(p, n, a[i], b[i], 1'b0);
        rs = floor_frac(p, n);
      end
      OP_CROSS: begin
        for (i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          k = (i + 2) % 3;
          p = 0; n = 0;
          mac(p, n, a[j], b[k], 1'b0);
          mac(p, n, a[k], b[j], 1'b1);
          rv[i] = floor_frac(p, n);
        end
      end
      OP_MAG: rs = clamp_sm(1'b0, root_floor(sa));
      OP_DIST: begin
        for (i = 0; i < 3; i++) sd = sd + umag(a[i] - b[i]) * umag(a[i] - b[i]);
        if (sd > (128'd1 << 62)) sd = 128'd1 << 62;
        rs = clamp_sm(1'b0, root_floor(sd));
      end
      OP_NORM, OP_TRUNC: begin
        m = root_floor(sa);
        if (sa == 0) begin
          zl = 1;
        end else begin
          for (i = 0; i < 3; i++) begin
            if (w.op == OP_NORM) begin
              rv[i] = clamp_sm(a[i] < 0, (umag(a[i]) << FRAC_BITS) / m);
            end else if (s >= 0 && umag(s) >= m) begin
              rv[i] = a[i][31:0];
            end else begin
              rv[i] = clamp_sm((a[i] < 0) != (s < 0), umag(a[i]) * umag(s) / m);
            end
          end
        end
      end
      OP_PROJ: begin
        if (sb == 0) begin
          zl = 1;
        end else begin
          for (i = 0; i < 3; i++) mac(p, n, a[i], b[i], 1'b0);
          dneg = p < n;
          dm = dneg ? n - p : p - n;
          for (i = 0; i < 3; i++) rv[i] = clamp_sm((b[i] < 0) != dneg, umag(b[i]) * dm / sb);
        end
      end
      OP_EQ: eq = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
      default: ;
    endcase
    r.rx = rv[0];
    r.ry = rv[1];
    r.rz = rv[2];
    r.rscalar = rs;
    r.equal_flag = eq;
    r.zero_length_error = zl;
    return r;
  endfunction

  initial begin
    err_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    out_t e;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        result_q.push_back(vec_result(in_data));
      end
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result word with nothing expected");
          err_count = err_count + 1;
        end else begin
          e = result_q.pop_front();
          if (out_data.rx !== e.rx) begin
            $error("rx expected %h got %h", e.rx, out_data.rx);
            err_count = err_count + 1;
          end
          if (out_data.ry !== e.ry) begin
            $error("ry expected %h got %h", e.ry, out_data.ry);
            err_count = err_count + 1;
          end
          if (out_data.rz !== e.rz) begin
            $error("rz expected %h got %h", e.rz, out_data.rz);
            err_count = err_count + 1;
          end
          if (out_data.rscalar !== e.rscalar) begin
            $error("rscalar expected %h got %h", e.rscalar, out_data.rscalar);
            err_count = err_count + 1;
          end
          if (out_data.equal_flag !== e.equal_flag) begin
            $error("equal_flag expected %b got %b", e.equal_flag, out_data.equal_flag);
            err_count = err_count + 1;
          end
          if (out_data.zero_length_error !== e.zero_length_error) begin
            $error("zero_length_error expected %b got %b", e.zero_length_error,
                   out_data.zero_length_error);
            err_count = err_count + 1;
          end
        end
      end
    end
    pending = result_q.size();
  end

endmodule

// ===== tb/vec3_math_unit_tb.sv =====
// Testbench top of the 3D vector maths unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module vec3_math_unit_tb;
  import v3m_pkg::*;

  localparam int NUM_RANDOM = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  int   err_count;
  int   pending;
  bit   hold_req = 0;
  bit   no_idle = 0;
  int   sent = 0;

  always #5 clk = ~clk;

  vec3_math_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  vec3_math_unit_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .err_count(err_count), .pending(pending)
  );

  function automatic logic [31:0] pick_val();
    case ($urandom_range(0, 7))
      0, 1, 2: return $urandom;
      3, 4, 5: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      6: begin
        case ($urandom_range(0, 5))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          3: return 32'h0000_0001;
          4: return 32'h0001_0000;
          default: return 32'hFFFF_0000;
        endcase
      end
      default: return 32'h0;
    endcase
  endfunction

  function automatic in_t mk_word(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b,
                                  input logic [31:0] s);
    in_t w;
    w.op = op;
    w.ax = a; w.ay = a; w.az = a;
    w.bx = b; w.by = b; w.bz = b;
    w.scalar_in = s;
    return w;
  endfunction

  task automatic send_word(input in_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    sent++;
    while (!no_idle && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 0;
      end
      out_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 10);
    end
  end

  initial begin
    in_t w;
    int  i, op;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (op = 0; op < 16; op++) begin
      send_word(mk_word(op[3:0], 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    end
    send_word(mk_word(OP_NORM, 32'h0, 32'h1234_5678, 32'h0001_0000));
    send_word(mk_word(OP_TRUNC, 32'h0, 32'h0, 32'h7FFF_FFFF));
    send_word(mk_word(OP_PROJ, 32'h0003_0000, 32'h0, 32'h0));
    send_word(mk_word(OP_EQ, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 32'h0));
    send_word(mk_word(OP_TRUNC, 32'h0003_0000, 32'h0, 32'hFFFF_0000));
    send_word(mk_word(OP_TRUNC, 32'h0003_0000, 32'h0, 32'h7FFF_FFFF));
    send_word(mk_word(OP_DIST, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
    send_word(mk_word(OP_SCALE, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001));

    for (i = 0; i < NUM_RANDOM; i++) begin
      if (i == 120) hold_req = 1;
      if (i == 250) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      no_idle = (i >= 300 && i < 380);
      op = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 15) : $urandom_range(0, 12);
      w.op = op[3:0];
      w.ax = pick_val(); w.ay = pick_val(); w.az = pick_val();
      w.bx = pick_val(); w.by = pick_val(); w.bz = pick_val();
      w.scalar_in = pick_val();
      if (w.op == OP_EQ && $urandom_range(0, 1)) begin
        w.bx = w.ax; w.by = w.ay; w.bz = w.az;
        if ($urandom_range(0, 2) == 0) w.bz = w.bz ^ (32'h1 << $urandom_range(0, 31));
      end
      if ((w.op == OP_NORM || w.op == OP_TRUNC) && $urandom_range(0, 9) == 0) begin
        w.ax = 0; w.ay = 0; w.az = 0;
      end
      if (w.op == OP_PROJ && $urandom_range(0, 9) == 0) begin
        w.bx = 0; w.by = 0; w.bz = 0;
      end
      send_word(w);
    end
    in_valid <= 1'b0;
    no_idle = 0;

    do @(posedge clk); while (pending != 0);
    repeat (100) @(posedge clk);
    $display("Covered %0d words: every op code incl. unused ones, extremes, zero lengths,", sent);
    $display("equal and near-equal vectors, a long output stall and a full drain pause.");
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
